// File: rtl/scmva_pkg.sv
// Shared types and constants for the sparse column matrix-vector accumulate unit.
// Used by every module of the block; depends on nothing else.
package scmva_pkg;

    localparam int ROWS_DEF  = 1024;
    localparam int ROW_W     = 10;
    localparam int VAL_W     = 32;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = 48;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 64;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [0:0] {
        FUNC_ACC  = 1'b0,
        FUNC_READ = 1'b1
    } t_func;

    typedef enum logic [0:0] {
        CLR_SWEEP = 1'b0,
        CLR_DONE  = 1'b1
    } t_clr_state;

endpackage

// File: rtl/scmva_acc_mem.sv
// Row accumulator store: one write port and one read port, registered read data.
// Uses scmva_pkg for the accumulator width.
module scmva_acc_mem #(
    parameter int ROWS = scmva_pkg::ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(ROWS)-1:0]       i_wr_addr,
    input  logic [scmva_pkg::ACC_W-1:0]   i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(ROWS)-1:0]       i_rd_addr,
    output logic [scmva_pkg::ACC_W-1:0]   o_rd_data
);

    logic [scmva_pkg::ACC_W-1:0] r_mem [ROWS];
    logic [scmva_pkg::ACC_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/scmva_clear_seq.sv
// Post-reset clearing sweep that zeroes every accumulator entry, one per cycle.
// Uses scmva_pkg for its state type.
module scmva_clear_seq #(
    parameter int ROWS = scmva_pkg::ROWS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    output logic                    o_busy,
    output logic [$clog2(ROWS)-1:0] o_addr
);

    localparam int AW = $clog2(ROWS);

    scmva_pkg::t_clr_state r_state, n_state;
    logic [AW-1:0]         r_cnt, n_cnt;
    logic                  last;

    assign last = (r_cnt == AW'(ROWS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scmva_pkg::CLR_SWEEP: if (last) n_state = scmva_pkg::CLR_DONE;
            scmva_pkg::CLR_DONE:  n_state = scmva_pkg::CLR_DONE;
            default:              n_state = scmva_pkg::CLR_DONE;
        endcase
    end

    always_comb begin
        o_busy = 1'b0;
        n_cnt  = r_cnt;
        unique case (r_state)
            scmva_pkg::CLR_SWEEP: begin
                o_busy = 1'b1;
                n_cnt  = r_cnt + AW'(1);
            end
            scmva_pkg::CLR_DONE: begin
                o_busy = 1'b0;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scmva_pkg::CLR_SWEEP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_addr = r_cnt;

endmodule

// File: rtl/sparse_column_matvec_accumulate_unit.sv
// Top level of the sparse column matrix-vector accumulate unit: three-stage
// read-modify-write pipeline around the row accumulator store.
// Depends on scmva_pkg, scmva_acc_mem and scmva_clear_seq.
//
//  channel  | direction | tdata fields (low bit up)                 | tuser
//  ---------+-----------+--------------------------------------------+------
//  s_axis   | in        | row_index, entry_value, column_rhs, pad    | func
//  m_axis   | out       | row_echo, row_sum, pad                     | -
//
// One request is taken per cycle unless the pipeline stalls or the store is
// being cleared; a read result passes in turn through the memory read, the
// registered multiplier and the add stage. After reset every entry of the
// store is cleared, during which no request is taken. Back-to-back requests
// to one row are served by forwarding from the add stage and the last write.
// The pipeline stalls only while a read result cannot be delivered.
module sparse_column_matvec_accumulate_unit #(
    parameter int ROWS = scmva_pkg::ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // row_index[9:0], entry_value[41:10], column_rhs[73:42], zero pad[79:74]
    input  logic [scmva_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // func[0]
    input  logic [0:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // row_echo[9:0], row_sum[57:10], zero pad[63:58]
    output logic [scmva_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int AW    = $clog2(ROWS);
    localparam int ROW_W = scmva_pkg::ROW_W;
    localparam int VAL_W = scmva_pkg::VAL_W;
    localparam int ACC_W = scmva_pkg::ACC_W;
    localparam int XW    = AW + ROW_W;

    // Input unpacking.
    logic                     accept;
    logic                     advance;
    logic                     out_free;
    logic [ROW_W-1:0]         in_row;
    logic [XW-1:0]            in_row_x;
    logic [AW-1:0]            in_addr;
    logic                     in_range;
    scmva_pkg::t_func         in_func;

    // Clearing sweep and memory.
    logic                     clr_busy;
    logic [AW-1:0]            clr_addr;
    logic                     mem_wr_en;
    logic [AW-1:0]            mem_wr_addr;
    logic [ACC_W-1:0]         mem_wr_data;
    logic [ACC_W-1:0]         mem_rd_data;

    // Stage 1: memory data arrives, multiply.
    logic                     r_s1_valid;
    scmva_pkg::t_func         r_s1_func;
    logic [ROW_W-1:0]         r_s1_row;
    logic [AW-1:0]            r_s1_addr;
    logic                     r_s1_in_range;
    logic signed [VAL_W-1:0]  r_s1_a;
    logic signed [VAL_W-1:0]  r_s1_b;
    logic signed [scmva_pkg::PROD_W-1:0] s1_prod;
    logic [ACC_W-1:0]         s1_old;

    // Stage 2: add, saturate, write back.
    logic                     r_s2_valid;
    scmva_pkg::t_func         r_s2_func;
    logic [ROW_W-1:0]         r_s2_row;
    logic [AW-1:0]            r_s2_addr;
    logic                     r_s2_in_range;
    logic [ACC_W-1:0]         r_s2_old;
    logic signed [scmva_pkg::PROD_W-1:0] r_s2_prod;
    logic [ACC_W-1:0]         s2_prod_q;
    logic [ACC_W:0]           s2_sum;
    logic [ACC_W-1:0]         s2_sat;
    logic [ACC_W-1:0]         s2_new;
    logic                     s2_wr;

    // Last write, for a read that overlapped it in the memory.
    logic                     r_wb_valid;
    logic [AW-1:0]            r_wb_addr;
    logic [ACC_W-1:0]         r_wb_data;

    // Output register.
    logic                     r_out_valid;
    logic [ROW_W-1:0]         r_out_row;
    logic [ACC_W-1:0]         r_out_sum;

    assign in_row   = i_s_axis_tdata[ROW_W-1:0];
    assign in_row_x = XW'(in_row);
    assign in_addr  = in_row_x[AW-1:0];
    assign in_range = (32'(in_row) < 32'(ROWS));
    assign in_func  = scmva_pkg::t_func'(i_s_axis_tuser[0]);

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign advance  = out_free || !(r_s2_valid && (r_s2_func == scmva_pkg::FUNC_READ));
    assign o_s_axis_tready = advance && !clr_busy;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;

    scmva_clear_seq #(
        .ROWS (ROWS)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_addr  (clr_addr)
    );

    assign mem_wr_en   = clr_busy || s2_wr;
    assign mem_wr_addr = clr_busy ? clr_addr : r_s2_addr;
    assign mem_wr_data = clr_busy ? '0 : s2_new;

    scmva_acc_mem #(
        .ROWS (ROWS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (in_addr),
        .o_rd_data (mem_rd_data)
    );

    // Stage 1 logic. The item ahead in stage 2 has the newest value of its row;
    // failing that, the last completed write may not yet be in the read data.
    assign s1_prod = r_s1_a * r_s1_b;

    always_comb begin
        if (r_s2_valid && r_s2_in_range && (r_s2_addr == r_s1_addr)) begin
            s1_old = s2_new;
        end else if (r_wb_valid && (r_wb_addr == r_s1_addr)) begin
            s1_old = r_wb_data;
        end else begin
            s1_old = mem_rd_data;
        end
    end

    // Stage 2 logic: the product drops its low fraction bits, rounding down.
    assign s2_prod_q = r_s2_prod[scmva_pkg::FRAC_W +: ACC_W];
    assign s2_sum    = {r_s2_old[ACC_W-1], r_s2_old} + {s2_prod_q[ACC_W-1], s2_prod_q};

    always_comb begin
        if (s2_sum[ACC_W] != s2_sum[ACC_W-1]) begin
            s2_sat = s2_sum[ACC_W] ? scmva_pkg::ACC_MIN : scmva_pkg::ACC_MAX;
        end else begin
            s2_sat = s2_sum[ACC_W-1:0];
        end
    end

    assign s2_new = (r_s2_func == scmva_pkg::FUNC_READ) ? '0 : s2_sat;
    assign s2_wr  = r_s2_valid && r_s2_in_range && advance;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_s1_valid <= accept;
                r_s2_valid <= r_s1_valid;
            end
            if (advance && r_s2_valid && (r_s2_func == scmva_pkg::FUNC_READ)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s2_wr) begin
                r_wb_valid <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func     <= in_func;
            r_s1_row      <= in_row;
            r_s1_addr     <= in_addr;
            r_s1_in_range <= in_range;
            r_s1_a        <= $signed(i_s_axis_tdata[ROW_W +: VAL_W]);
            r_s1_b        <= $signed(i_s_axis_tdata[ROW_W + VAL_W +: VAL_W]);
        end
        if (advance) begin
            r_s2_func     <= r_s1_func;
            r_s2_row      <= r_s1_row;
            r_s2_addr     <= r_s1_addr;
            r_s2_in_range <= r_s1_in_range;
            r_s2_old      <= s1_old;
            r_s2_prod     <= s1_prod;
        end
        if (s2_wr) begin
            r_wb_addr <= r_s2_addr;
            r_wb_data <= s2_new;
        end
        if (advance && r_s2_valid && (r_s2_func == scmva_pkg::FUNC_READ)) begin
            r_out_row <= r_s2_row;
            r_out_sum <= r_s2_in_range ? r_s2_old : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = scmva_pkg::M_TDATA_W'({r_out_sum, r_out_row});

endmodule
